// ----- rtl/core/torq_pkg.sv -----
// torq_pkg: sizes, entry type, status and operation codes of the
// timestamp-ordered request queue. No dependencies.

package torq_pkg;

  localparam int DEPTH       = 16;
  localparam int TIME_BITS   = 15;
  localparam int PROC_BITS   = 4;
  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] ts;
    logic [PROC_BITS-1:0] proc;
  } entry_t;

  // Held entry sorts strictly below the new key: timestamp first, then id.
  function automatic logic key_less(entry_t held, entry_t key);
    return {held.ts, held.proc} < {key.ts, key.proc};
  endfunction

endpackage

// ----- rtl/core/timestamp_ordered_request_queue_top.sv -----
// Timestamp-ordered request queue: sorted mutual-exclusion request store
// held in one synchronous RAM, insert walk and result register. Uses torq_pkg.
//
//  channel | direction | signals                          | transaction
//  --------+-----------+----------------------------------+---------------------------
//  req     | in        | req_valid/req_ready, func,       | one push or pop
//          |           | req_time, req_proc               |
//  rsp     | out       | rsp_valid/rsp_ready, head_time,  | head, count and status
//          |           | head_proc, head_valid, count,    | after that operation
//          |           | status                           |
//
// Walk: a push into a queue that is neither empty nor full runs the tail-to-head
// walk, which reads one entry per cycle through the single RAM read port;
// an empty or full push and a pop do not walk.
// One transaction is in work at a time; the result register holds the last
// result, so the next transaction is taken while a result waits.
// Reset: synchronous, clears the count, ring base and handshake state; the
// RAM is not cleared, and only entries below the count are used.
// Stalls: rsp_ready low holds the result register; work that finishes then
// waits in the hand-off state.

module timestamp_ordered_request_queue_top
  import torq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic                   func,
  input  logic [TIME_BITS-1:0]   req_time,
  input  logic [PROC_BITS-1:0]   req_proc,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic [TIME_BITS-1:0]   head_time,
  output logic [PROC_BITS-1:0]   head_proc,
  output logic                   head_valid,
  output logic [COUNT_BITS-1:0]  count,
  output logic [STATUS_BITS-1:0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_t;

  state_t     state;
  logic [PTR_W-1:0] base;       // physical slot of the head
  logic [CNT_W-1:0] n;          // entries held
  logic [CNT_W-1:0] idx;        // logical slot being filled during the walk
  entry_t     pend;             // request being inserted
  entry_t     head;             // copy of the head entry
  status_t    st;

  // Entry RAM, one read and one write port, registered read data.
  entry_t           mem [DEPTH];
  entry_t           rd_data;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  entry_t           wr_data;

  entry_t           req_entry;
  logic             rsp_free;

  // Map a logical queue position onto the ring.
  function automatic logic [PTR_W-1:0] phys(logic [PTR_W-1:0] b, logic [CNT_W-1:0] l);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(b) + (CNT_W + 1)'(l);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign req_entry = '{ts: req_time, proc: req_proc};
  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // RAM port control per state.
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = pend;
    case (state)
      S_IDLE: begin
        if (func == FUNC_POP) begin
          rd_addr = phys(base, CNT_W'(1));
        end else if (n == '0) begin
          // empty queue: write the request straight into the head slot
          wr_en   = req_valid;
          wr_addr = base;
          wr_data = req_entry;
        end else begin
          rd_addr = phys(base, n - CNT_W'(1));
        end
      end
      S_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = phys(base, idx);
        wr_data = key_less(rd_data, pend) ? pend : rd_data;
        if (idx >= CNT_W'(2)) begin
          rd_addr = phys(base, idx - CNT_W'(2));
        end
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = base;
        wr_data = pend;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base       <= '0;
      n          <= '0;
      idx        <= '0;
      st         <= ST_OK;
      rsp_valid  <= 1'b0;
    end else begin
      // drop the accepted result unless a new one is loaded in this cycle
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            pend <= req_entry;
            st   <= ST_OK;
            if (func == FUNC_POP) begin
              if (n == '0) begin
                st    <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                // advance the ring; fetch the new head if one remains
                base  <= phys(base, CNT_W'(1));
                n     <= n - CNT_W'(1);
                state <= (n == CNT_W'(1)) ? S_DONE : S_POP_RD;
              end
            end else if (n == CNT_W'(DEPTH)) begin
              st    <= ST_FULL;
              state <= S_DONE;
            end else if (n == '0) begin
              head  <= req_entry;
              n     <= CNT_W'(1);
              state <= S_DONE;
            end else begin
              idx   <= n;
              n     <= n + CNT_W'(1);
              state <= S_SCAN;
            end
          end
        end
        S_POP_RD: begin
          head  <= rd_data;
          state <= S_DONE;
        end
        S_SCAN: begin
          // rd_data holds logical slot idx-1: stop below it or shift it up
          if (key_less(rd_data, pend)) begin
            state <= S_DONE;
          end else if (idx == CNT_W'(1)) begin
            state <= S_PLACE;
          end else begin
            idx <= idx - CNT_W'(1);
          end
        end
        S_PLACE: begin
          head  <= pend;
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid  <= 1'b1;
            head_valid <= (n != '0);
            head_time  <= (n != '0) ? head.ts : '0;
            head_proc  <= (n != '0) ? head.proc : '0;
            count      <= COUNT_BITS'(n);
            status     <= st;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/torq_checker.sv -----
// torq_checker: port-level assertions for the request queue, bound to
// timestamp_ordered_request_queue_top. Uses torq_pkg.

module torq_checker
  import torq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   func,
  input logic [TIME_BITS-1:0]   req_time,
  input logic [PROC_BITS-1:0]   req_proc,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [TIME_BITS-1:0]   head_time,
  input logic [PROC_BITS-1:0]   head_proc,
  input logic                   head_valid,
  input logic [COUNT_BITS-1:0]  count,
  input logic [STATUS_BITS-1:0] status
);

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(head_time) && $stable(count)
      && $stable(status))
    else $error("result changed while stalled");

  // Empty queue shows a cleared head; a valid head means entries are held.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (head_valid == (count != '0))
      && (head_valid || (head_time == '0 && head_proc == '0)))
    else $error("head fields disagree with count");

  // A dropped push is reported only on a full queue.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> count == COUNT_BITS'(DEPTH))
    else $error("full status with room left");

  // A pop on an empty queue leaves it empty.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> count == '0)
    else $error("empty status with entries held");

  // Count never exceeds the depth; status never carries an unused code.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> count <= COUNT_BITS'(DEPTH)
      && (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
    else $error("count or status out of range");

endmodule

bind timestamp_ordered_request_queue_top torq_checker u_torq_checker (.*);

// ----- verif/timestamp_ordered_request_queue_top_test.sv -----
// Self-checking bench for the timestamp-ordered request queue: random and directed pushes
// and pops, with a sorted-queue predictor checking every result. Depends on torq_pkg and
// timestamp_ordered_request_queue_top.
`timescale 1ns / 1ps

module timestamp_ordered_request_queue_top_test;
  import torq_pkg::*;

  // One push or pop as offered on the request channel
  typedef struct {
    logic                 op;
    logic [TIME_BITS-1:0] ts;
    logic [PROC_BITS-1:0] proc;
  } request_t;

  // Head, count and status that one transaction must return
  typedef struct {
    logic [TIME_BITS-1:0]  ts;
    logic [PROC_BITS-1:0]  proc;
    logic                  valid;
    logic [COUNT_BITS-1:0] cnt;
    status_t               st;
  } head_report_t;

  localparam int RANDOM_REQS   = 1828;
  localparam int QUIET_TAIL    = 150;  // last requests go through with no idling
  localparam int HOLDOFF_AFTER = 300;  // accepted requests before the long hold-off
  localparam int HOLDOFF_LEN   = 400;
  localparam int DRAIN_CYCLES  = 30;
  localparam int PRINT_CAP     = 100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  logic                   func = FUNC_PUSH;
  logic [TIME_BITS-1:0]   req_time = '0;
  logic [PROC_BITS-1:0]   req_proc = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  logic [TIME_BITS-1:0]   head_time;
  logic [PROC_BITS-1:0]   head_proc;
  logic                   head_valid;
  logic [COUNT_BITS-1:0]  count;
  logic [STATUS_BITS-1:0] status;

  request_t     pending_reqs[$];      // requests still to be offered
  entry_t       sorted_reqs[$];       // predicted queue contents, head first
  head_report_t head_reports_due[$];  // predicted results, oldest first

  request_t     on_bus;
  head_report_t want;
  int           total_reqs = 0;
  int           reports_seen = 0;
  int           mismatch_total = 0;
  int           accepted_cnt = 0;
  bit           tail_quiet = 1'b0;
  int           send_gap = 0;
  bit           send_idle_on = 1'b1;
  int           recv_stall = 0;
  bit           recv_idle_on = 1'b1;
  int           holdoff_left = 0;
  bit           holdoff_used = 1'b0;

  timestamp_ordered_request_queue_top u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .func       (func),
    .req_time   (req_time),
    .req_proc   (req_proc),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .head_time  (head_time),
    .head_proc  (head_proc),
    .head_valid (head_valid),
    .count      (count),
    .status     (status)
  );

  always #5 clk = ~clk;

  // Apply one request to the predicted queue and return what the block must report.
  // A push walks past every held entry that sorts strictly below the new key, so it
  // lands ahead of any entry with an equal key; a full queue drops it unchanged.
  function automatic head_report_t apply_request(request_t r);
    head_report_t res;
    entry_t       key;
    int           pos;
    key.ts   = r.ts;
    key.proc = r.proc;
    res.st   = ST_OK;
    if (r.op == FUNC_PUSH) begin
      if (sorted_reqs.size() >= DEPTH) begin
        res.st = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_reqs.size() &&
               (sorted_reqs[pos].ts < r.ts ||
                (sorted_reqs[pos].ts == r.ts && sorted_reqs[pos].proc < r.proc)))
          pos++;
        sorted_reqs.insert(pos, key);
      end
    end else if (sorted_reqs.size() == 0) begin
      res.st = ST_EMPTY;
    end else begin
      void'(sorted_reqs.pop_front());
    end
    // An empty queue reports a zero head with the valid flag low
    res.valid = (sorted_reqs.size() != 0);
    res.ts    = res.valid ? sorted_reqs[0].ts : '0;
    res.proc  = res.valid ? sorted_reqs[0].proc : '0;
    res.cnt   = COUNT_BITS'(sorted_reqs.size());
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    mismatch_total++;
    if (mismatch_total <= PRINT_CAP)
      $display("[%0t] result %0d: %s got %0d, expected %0d",
               $realtime, reports_seen, what, got, exp_val);
  endtask

  task automatic add_request(logic op, int unsigned ts, int unsigned proc);
    request_t r;
    r.op   = op;
    r.ts   = ts[TIME_BITS-1:0];
    r.proc = proc[PROC_BITS-1:0];
    pending_reqs.push_back(r);
  endtask

  // Driver: offer pending requests, predict each one at the edge where it is taken.
  // Valid holds high with a steady payload until the transaction is accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && req_ready) begin
        head_reports_due.push_back(apply_request(on_bus));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!req_valid || req_ready) begin
        // Start an idle burst now and then, but never in the quiet tail
        if (send_gap == 0 && send_idle_on && !tail_quiet && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 13);
        if (send_gap != 0 || pending_reqs.size() == 0) begin
          req_valid <= 1'b0;
          if (send_gap != 0)
            send_gap--;
        end else begin
          on_bus = pending_reqs.pop_front();
          func      <= on_bus.op;
          req_time  <= on_bus.ts;
          req_proc  <= on_bus.proc;
          req_valid <= 1'b1;
          // Flip between idling and back-to-back stretches
          if ($urandom_range(0, 49) == 0)
            send_idle_on = ~send_idle_on;
        end
      end
      tail_quiet <= (pending_reqs.size() < QUIET_TAIL);
    end
  end

  // Long receiver hold-off, counted here: the sender keeps offering, so the result
  // register and the request in work back up and the block stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_used <= 1'b0;
    end else if (!holdoff_used && accepted_cnt >= HOLDOFF_AFTER) begin
      holdoff_left <= HOLDOFF_LEN;
      holdoff_used <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Monitor: check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (head_reports_due.size() == 0) begin
          report_mismatch("unexpected result, count", count, 0);
        end else begin
          want = head_reports_due.pop_front();
          if (head_time !== want.ts)
            report_mismatch("head_time", head_time, want.ts);
          if (head_proc !== want.proc)
            report_mismatch("head_proc", head_proc, want.proc);
          if (head_valid !== want.valid)
            report_mismatch("head_valid", head_valid, want.valid);
          if (count !== want.cnt)
            report_mismatch("count", count, want.cnt);
          if (status !== want.st)
            report_mismatch("status", status, want.st);
        end
        reports_seen++;
        if ($urandom_range(0, 99) == 0)
          recv_idle_on = ~recv_idle_on;
      end
      if (recv_stall == 0 && recv_idle_on && !tail_quiet && $urandom_range(0, 5) == 0)
        recv_stall = $urandom_range(1, 13);
      if (holdoff_left != 0 || recv_stall != 0) begin
        rsp_ready <= 1'b0;
        if (recv_stall != 0)
          recv_stall--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int          seg_len;
    int          push_pct;
    int          span;
    int unsigned base_ts;
    int unsigned ts;
    int          made;
    logic        op;

    // Directed: pop on an empty queue, then fill with field extremes and equal keys
    add_request(FUNC_POP, 32767, 15);
    add_request(FUNC_PUSH, 16383, 7);
    add_request(FUNC_PUSH, 0, 0);
    add_request(FUNC_PUSH, 32767, 15);
    add_request(FUNC_PUSH, 0, 0);
    add_request(FUNC_PUSH, 32767, 0);
    add_request(FUNC_PUSH, 0, 15);
    add_request(FUNC_PUSH, 21845, 10);
    add_request(FUNC_PUSH, 10922, 5);
    add_request(FUNC_PUSH, 16383, 7);
    add_request(FUNC_PUSH, 100, 3);
    add_request(FUNC_PUSH, 100, 2);
    add_request(FUNC_PUSH, 100, 3);
    add_request(FUNC_PUSH, 32766, 14);
    add_request(FUNC_PUSH, 1, 1);
    add_request(FUNC_PUSH, 2, 8);
    add_request(FUNC_PUSH, 16384, 8);
    // Queue now full: drop this push, then take a few off the head
    add_request(FUNC_PUSH, 5, 5);
    repeat (4) add_request(FUNC_POP, 0, 0);

    // Random: segments biased towards filling, draining or churning, so the count
    // sweeps from empty to full and back; narrow timestamp spans give many ties.
    made = 0;
    while (made < RANDOM_REQS) begin
      seg_len = $urandom_range(8, 48);
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = 95;
      endcase
      span    = $urandom_range(0, 2);
      base_ts = $urandom_range(0, 32763);
      for (int k = 0; k < seg_len && made < RANDOM_REQS; k++) begin
        op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        case (span)
          0:       ts = base_ts + $urandom_range(0, 3);
          1:       ts = $urandom_range(0, 32767);
          default: ts = $urandom_range(0, 1) ? $urandom_range(32760, 32767)
                                             : $urandom_range(0, 7);
        endcase
        // Pops carry random noise in the ignored fields
        add_request(op, ts, $urandom_range(0, 15));
        made++;
      end
    end
    total_reqs = pending_reqs.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Every request yields one result: wait for them all, then let stray ones show
    while (reports_seen < total_reqs) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && head_reports_due.size() == 0) begin
      $display("timestamp_ordered_request_queue_top: match");
    end else begin
      $display("timestamp_ordered_request_queue_top: mismatch");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a millisecond of simulated time
  initial begin
    #5_000_000;
    $display("timestamp_ordered_request_queue_top: mismatch");
    $finish;
  end

endmodule
